>>> src/tst_pkg.sv
// shared types and constants for the timeout slot table
// used by tst_ctrl, tst_datapath and timeout_slot_table; no dependencies
`default_nettype none

package tst_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    // slot field is 4 bits, so at most 16 slots take part
    localparam int RESULT_CAP    = 16;
    localparam int SLOT_W        = 4;
    localparam int HANDLE_W      = 32;
    localparam int TICKS_W       = 16;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    typedef struct packed {
        logic add_en;
        logic tick_en;
        logic step_en;
    } cmd_t;

    typedef struct packed {
        logic pend;
        logic cur_hit;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> src/timeout_slot_table.sv
// top level of the timeout slot table: controller plus datapath
// depends on tst_pkg, tst_ctrl, tst_datapath
//
// channel  direction  handshake            payload
// in       request    in_valid / in_stall   op, handle, arg_handle, has_arg, ticks
// out      result     out_valid / out_stall slot, handle_out, arg_out, has_arg_out, last
//
// an add request writes the lowest free slot in place
// a tick updates all counts at once, then the scan steps through the slots up to
// the highest expiring slot and then returns to idle; it waits on a hit
// while the output register is stalled
// in_stall stays high during the scan; the output register holds one result
// reset clears every busy bit at once, no clearing pass
`default_nettype none

module timeout_slot_table
#(
    parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [tst_pkg::HANDLE_W-1:0]  handle,
    input  wire logic [tst_pkg::HANDLE_W-1:0]  arg_handle,
    input  wire logic                          has_arg,
    input  wire logic [tst_pkg::TICKS_W-1:0]   ticks,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tst_pkg::SLOT_W-1:0]         slot,
    output logic [tst_pkg::HANDLE_W-1:0]       handle_out,
    output logic [tst_pkg::HANDLE_W-1:0]       arg_out,
    output logic                               has_arg_out,
    output logic                               last
);

    tst_pkg::cmd_t    cmd;
    tst_pkg::status_t status;

    tst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tst_datapath
    #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .handle      (handle),
        .arg_handle  (arg_handle),
        .has_arg     (has_arg),
        .ticks       (ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot        (slot),
        .handle_out  (handle_out),
        .arg_out     (arg_out),
        .has_arg_out (has_arg_out),
        .last        (last)
    );

endmodule

`default_nettype wire

>>> src/tst_ctrl.sv
// controller for the timeout slot table: idle / scan sequencing
// depends on tst_pkg
`default_nettype none

module tst_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              op,
    output logic                   in_stall,
    input  wire tst_pkg::status_t  status,
    output tst_pkg::cmd_t          cmd
);

    tst_pkg::state_t state_reg;
    tst_pkg::state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        unique case (state_reg)
            tst_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (op == tst_pkg::OP_TICK)
                    begin
                        cmd.tick_en = 1'b1;
                        state_next  = tst_pkg::ST_SCAN;
                    end
                    else
                    begin
                        cmd.add_en = 1'b1;
                    end
                end
            end
            tst_pkg::ST_SCAN:
            begin
                // skip empty slots, wait on the output register for hits
                if (!status.pend)
                begin
                    state_next = tst_pkg::ST_IDLE;
                end
                else if (!status.cur_hit || status.out_free)
                begin
                    cmd.step_en = 1'b1;
                end
            end
            default:
            begin
                state_next = tst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> src/tst_datapath.sv
// slot storage, tick update, expiry scan and output register
// depends on tst_pkg; driven by tst_ctrl through cmd_t / status_t
`default_nettype none

module tst_datapath
#(
    parameter int NUM_SLOTS = tst_pkg::NUM_SLOTS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tst_pkg::cmd_t                 cmd,
    output tst_pkg::status_t                   status,
    input  wire logic [tst_pkg::HANDLE_W-1:0]  handle,
    input  wire logic [tst_pkg::HANDLE_W-1:0]  arg_handle,
    input  wire logic                          has_arg,
    input  wire logic [tst_pkg::TICKS_W-1:0]   ticks,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tst_pkg::SLOT_W-1:0]         slot,
    output logic [tst_pkg::HANDLE_W-1:0]       handle_out,
    output logic [tst_pkg::HANDLE_W-1:0]       arg_out,
    output logic                               has_arg_out,
    output logic                               last
);

    localparam int USED  = (NUM_SLOTS < tst_pkg::RESULT_CAP) ? NUM_SLOTS
                                                               : tst_pkg::RESULT_CAP;
    localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;

    logic [USED-1:0]                  busy_reg;
    logic [USED-1:0]                  busy_next;
    logic [USED-1:0]                  mask_reg;
    logic [USED-1:0]                  mask_next;
    logic [IDX_W-1:0]                 idx_reg;
    logic [IDX_W-1:0]                 idx_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    logic [tst_pkg::TICKS_W-1:0]      remaining_reg [USED];
    logic [tst_pkg::HANDLE_W-1:0]     handle_reg    [USED];
    logic [tst_pkg::HANDLE_W-1:0]     arg_reg       [USED];
    logic [USED-1:0]                  has_arg_reg;

    logic [tst_pkg::SLOT_W-1:0]       slot_reg;
    logic [tst_pkg::HANDLE_W-1:0]     handle_out_reg;
    logic [tst_pkg::HANDLE_W-1:0]     arg_out_reg;
    logic                             has_arg_out_reg;
    logic                             last_reg;

    logic [USED-1:0]                  expire;
    logic [IDX_W-1:0]                 free_idx;
    logic                             free_found;
    logic [USED-1:0]                  mask_clr;
    logic                             load;
    logic                             out_take;

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < USED; i++)
        begin
            if (!busy_reg[i] && !free_found)
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < USED; i++)
        begin
            expire[i] = busy_reg[i] && (remaining_reg[i] <= tst_pkg::TICKS_W'(1));
        end
    end

    assign mask_clr = mask_reg & ~(USED'(1) << idx_reg);
    assign load     = cmd.step_en && mask_reg[idx_reg];
    assign out_take = out_valid_reg && !out_stall;

    assign status.pend     = |mask_reg;
    assign status.cur_hit  = mask_reg[idx_reg];
    assign status.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        busy_next      = busy_reg;
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_take;
        if (cmd.add_en && free_found)
        begin
            busy_next[free_idx] = 1'b1;
        end
        if (cmd.tick_en)
        begin
            busy_next = busy_reg & ~expire;
            mask_next = expire;
            idx_next  = '0;
        end
        if (cmd.step_en)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (load)
            begin
                mask_next      = mask_clr;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            mask_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            mask_reg      <= mask_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.add_en && free_found)
        begin
            remaining_reg[free_idx] <= ticks;
            handle_reg[free_idx]    <= handle;
            arg_reg[free_idx]       <= has_arg ? arg_handle : '0;
            has_arg_reg[free_idx]   <= has_arg;
        end
        if (cmd.tick_en)
        begin
            for (int i = 0; i < USED; i++)
            begin
                if (busy_reg[i] && !expire[i])
                begin
                    remaining_reg[i] <= remaining_reg[i] - tst_pkg::TICKS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg        <= tst_pkg::SLOT_W'(idx_reg);
            handle_out_reg  <= handle_reg[idx_reg];
            arg_out_reg     <= arg_reg[idx_reg];
            has_arg_out_reg <= has_arg_reg[idx_reg];
            last_reg        <= (mask_clr == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign slot        = slot_reg;
    assign handle_out  = handle_out_reg;
    assign arg_out     = arg_out_reg;
    assign has_arg_out = has_arg_out_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    a_mask_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg & busy_reg) == '0)
        else $error("pending expiry on a busy slot");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a stalled result");

    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_en |-> (mask_reg == '0) && !cmd.step_en)
        else $error("tick accepted during a scan");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        load && (mask_clr == '0) |=> !status.pend)
        else $error("scan continues after the last result");
`endif

endmodule

`default_nettype wire

>>> dv/tb_timeout_slot_table.sv
`timescale 1ns / 100ps
// testbench for timeout_slot_table: a directed table of add/tick requests, then random ones
// expiries are checked against a timer table kept inside the bench, or against those typed into fixed rows
// depends on tst_pkg and the timeout_slot_table rtl

module tb_timeout_slot_table;

    localparam int TABLE_SLOTS     = tst_pkg::NUM_SLOTS_DEF;
    localparam int LIVE_SLOTS      = (TABLE_SLOTS < tst_pkg::RESULT_CAP) ? TABLE_SLOTS
                                                                         : tst_pkg::RESULT_CAP;
    localparam int RANDOM_REQUESTS = 185;
    // room for a full scan plus a stalled result
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic                         op;
        logic [tst_pkg::HANDLE_W-1:0] handle;
        logic [tst_pkg::HANDLE_W-1:0] arg_handle;
        logic                         has_arg;
        logic [tst_pkg::TICKS_W-1:0]  ticks;
    } timer_request_t;

    typedef struct packed {
        logic [tst_pkg::SLOT_W-1:0]   slot;
        logic [tst_pkg::HANDLE_W-1:0] handle;
        logic [tst_pkg::HANDLE_W-1:0] arg;
        logic                         has_arg;
        logic                         last;
    } expiry_t;

    // fixed rows carry their expiry typed in; fixed_hit = 0 means a quiet tick
    typedef struct packed {
        timer_request_t req;
        logic           fixed;
        logic           fixed_hit;
        expiry_t        fixed_exp;
    } stim_row_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic                         op          = tst_pkg::OP_ADD;
    logic [tst_pkg::HANDLE_W-1:0] handle      = '0;
    logic [tst_pkg::HANDLE_W-1:0] arg_handle  = '0;
    logic                         has_arg     = 1'b0;
    logic [tst_pkg::TICKS_W-1:0]  ticks       = '0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic [tst_pkg::SLOT_W-1:0]   slot;
    logic [tst_pkg::HANDLE_W-1:0] handle_out;
    logic [tst_pkg::HANDLE_W-1:0] arg_out;
    logic                         has_arg_out;
    logic                         last;

    // timer table mirror
    logic                         tmr_busy    [TABLE_SLOTS];
    logic [tst_pkg::TICKS_W-1:0]  tmr_count   [TABLE_SLOTS];
    logic [tst_pkg::HANDLE_W-1:0] tmr_handle  [TABLE_SLOTS];
    logic [tst_pkg::HANDLE_W-1:0] tmr_arg     [TABLE_SLOTS];
    logic                         tmr_has_arg [TABLE_SLOTS];

    expiry_t expiries_due[$];
    int      mismatch_count = 0;
    int      burst_left     = 0;
    int      stall_cycle    = 0;

    timeout_slot_table #(
        .NUM_SLOTS   (TABLE_SLOTS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .handle      (handle),
        .arg_handle  (arg_handle),
        .has_arg     (has_arg),
        .ticks       (ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot        (slot),
        .handle_out  (handle_out),
        .arg_out     (arg_out),
        .has_arg_out (has_arg_out),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // add fills the lowest free slot; tick expires counts of 0 or 1 and decrements the rest
    task automatic advance_timer_table(input timer_request_t r, output expiry_t fired[$]);
        expiry_t e;
        int      i;
        logic    placed;
        fired  = {};
        placed = 1'b0;
        if (r.op == tst_pkg::OP_ADD)
        begin
            for (i = 0; i < LIVE_SLOTS; i++)
            begin
                if (!placed && !tmr_busy[i])
                begin
                    tmr_busy[i]    = 1'b1;
                    tmr_handle[i]  = r.handle;
                    tmr_has_arg[i] = r.has_arg;
                    tmr_arg[i]     = r.has_arg ? r.arg_handle : '0;
                    tmr_count[i]   = r.ticks;
                    placed         = 1'b1;
                end
            end
        end
        else
        begin
            for (i = 0; i < LIVE_SLOTS; i++)
            begin
                if (tmr_busy[i])
                begin
                    if (tmr_count[i] <= 1)
                    begin
                        e.slot    = tst_pkg::SLOT_W'(i);
                        e.handle  = tmr_handle[i];
                        e.arg     = tmr_has_arg[i] ? tmr_arg[i] : '0;
                        e.has_arg = tmr_has_arg[i];
                        e.last    = 1'b0;
                        fired.push_back(e);
                        tmr_busy[i] = 1'b0;
                    end
                    else
                    begin
                        tmr_count[i] = tmr_count[i] - 1'b1;
                    end
                end
            end
            if (fired.size() > 0)
                fired[fired.size() - 1].last = 1'b1;
        end
    endtask

    // drive one request in bursts with random gaps, return at the edge that takes it
    task automatic send_request(input stim_row_t row);
        expiry_t fired[$];
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        op         <= row.req.op;
        handle     <= row.req.handle;
        arg_handle <= row.req.arg_handle;
        has_arg    <= row.req.has_arg;
        ticks      <= row.req.ticks;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        advance_timer_table(row.req, fired);
        if (row.fixed)
        begin
            fired = {};
            if (row.fixed_hit)
                fired.push_back(row.fixed_exp);
        end
        foreach (fired[j])
            expiries_due.push_back(fired[j]);
    endtask

    initial
    begin
        stim_row_t directed_rows[$];
        stim_row_t row;
        int        k;
        int        pick;

        foreach (tmr_busy[i])
        begin
            tmr_busy[i]    = 1'b0;
            tmr_count[i]   = '0;
            tmr_handle[i]  = '0;
            tmr_arg[i]     = '0;
            tmr_has_arg[i] = 1'b0;
        end

        // quiet tick on an empty table
        row = '0;
        row.req.op = tst_pkg::OP_TICK;
        row.fixed  = 1'b1;
        directed_rows.push_back(row);
        // all ones, zero count expires on the next tick
        row = '0;
        row.req = '{tst_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000};
        directed_rows.push_back(row);
        row = '0;
        row.req.op     = tst_pkg::OP_TICK;
        row.fixed      = 1'b1;
        row.fixed_hit  = 1'b1;
        row.fixed_exp  = '{4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1};
        directed_rows.push_back(row);
        // no argument: stored arg must read back as zero
        row = '0;
        row.req = '{tst_pkg::OP_ADD, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 16'h0001};
        directed_rows.push_back(row);
        row = '0;
        row.req.op     = tst_pkg::OP_TICK;
        row.fixed      = 1'b1;
        row.fixed_hit  = 1'b1;
        row.fixed_exp  = '{4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1};
        directed_rows.push_back(row);
        // fill every slot, all due on the next tick
        for (k = 0; k < LIVE_SLOTS; k++)
        begin
            row = '0;
            row.req = '{tst_pkg::OP_ADD, 32'h5A5A_0000 | 32'(k),
                        32'hC3C3_0000 | 32'(k << 4), 1'(k % 2), 16'(k % 2)};
            directed_rows.push_back(row);
        end
        // table full, this add is dropped
        row = '0;
        row.req = '{tst_pkg::OP_ADD, 32'hDEAD_0000, 32'h0000_BEEF, 1'b1, 16'h0000};
        directed_rows.push_back(row);
        row = '0;
        row.req.op = tst_pkg::OP_TICK;
        directed_rows.push_back(row);
        // max count parks in slot 0, count of two needs a quiet tick first
        row = '0;
        row.req = '{tst_pkg::OP_ADD, 32'h0F0F_F0F0, 32'h1234_5678, 1'b1, 16'hFFFF};
        directed_rows.push_back(row);
        row = '0;
        row.req = '{tst_pkg::OP_ADD, 32'h8000_0001, 32'h7FFF_FFFE, 1'b1, 16'h0002};
        directed_rows.push_back(row);
        row = '0;
        row.req.op = tst_pkg::OP_TICK;
        directed_rows.push_back(row);
        directed_rows.push_back(row);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        for (k = 0; k < RANDOM_REQUESTS; k++)
        begin
            row = '0;
            row.req.op         = ($urandom_range(0, 99) < 38) ? tst_pkg::OP_TICK
                                                              : tst_pkg::OP_ADD;
            row.req.handle     = $urandom;
            row.req.arg_handle = $urandom;
            row.req.has_arg    = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 39);
            // mostly short counts so slots cycle; a rare long one stays parked
            if (pick == 0)
                row.req.ticks = 16'($urandom);
            else if (pick < 10)
                row.req.ticks = 16'($urandom_range(4, 24));
            else
                row.req.ticks = 16'($urandom_range(0, 3));
            send_request(row);
        end
        in_valid <= 1'b0;

        while (expiries_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result check and receiver stall pattern
    always @(posedge clk)
    begin : expiry_check
        expiry_t want;
        int      stall_mode;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expiries_due.size() == 0)
            begin
                $display("%0t: unexpected expiry: expected none, got slot %0d handle %h",
                         $time, slot, handle_out);
                $display("%0t:                    arg %h has_arg %0b last %0b",
                         $time, arg_out, has_arg_out, last);
                mismatch_count++;
            end
            else
            begin
                want = expiries_due.pop_front();
                if (slot !== want.slot || handle_out !== want.handle || arg_out !== want.arg ||
                    has_arg_out !== want.has_arg || last !== want.last)
                begin
                    $display("%0t: expiry mismatch: expected slot %0d handle %h arg %h",
                             $time, want.slot, want.handle, want.arg);
                    $display("%0t:                  expected has_arg %0b last %0b",
                             $time, want.has_arg, want.last);
                    $display("%0t:                  actual slot %0d handle %h arg %h",
                             $time, slot, handle_out, arg_out);
                    $display("%0t:                  actual has_arg %0b last %0b",
                             $time, has_arg_out, last);
                    mismatch_count++;
                end
            end
        end
        stall_cycle++;
        stall_mode = (stall_cycle / 256) % 4;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

endmodule

>>> filelist.f
src/tst_pkg.sv
src/tst_ctrl.sv
src/tst_datapath.sv
src/timeout_slot_table.sv
dv/tb_timeout_slot_table.sv
